// ===== hdl/rx_frame_checker_top_defines.svh =====
// Assertion macros for the received-frame checker.
`ifndef RX_FRAME_CHECKER_TOP_DEFINES_SVH
`define RX_FRAME_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTH
// Property that holds at every clock edge outside reset
`define RFC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("rx_frame_checker assertion failed");
// Consequence that must hold in the cycle after the antecedent
`define RFC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rx_frame_checker assertion failed");
`else
`define RFC_ASSERT_ALWAYS(lbl, prop)
`define RFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/rfc_pkg.sv =====
// Types and constants shared by the received-frame checker modules.
package rfc_pkg;

   // Largest frame in bytes, header and checksum included
   localparam int MAX_FRAME   = 128;
   // Index of the length byte within a frame
   localparam int LEN_POS     = 4;
   // Bytes in a frame beyond the length code
   localparam int EXTRA_BYTES = 6;

   // Configuration register indexes
   localparam logic [7:0] REG_HEADER_VALUE  = 8'd0;
   localparam logic [7:0] REG_LENGTH_CODE_A = 8'd1;
   localparam logic [7:0] REG_LENGTH_CODE_B = 8'd2;
   localparam logic [7:0] REG_LENGTH_CODE_C = 8'd3;

   // Configuration reset values
   localparam logic [7:0] HEADER_RESET = 8'hBB;
   localparam logic [6:0] CODE_A_RESET = 7'h37;
   localparam logic [6:0] CODE_B_RESET = 7'h3B;
   localparam logic [6:0] CODE_C_RESET = 7'h3E;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_RECV = 2'd1
   } phase_type;

   typedef enum logic [2:0] {
      ST_ONGOING  = 3'd0,
      ST_GOOD     = 3'd1,
      ST_CSUM_ERR = 3'd2,
      ST_LEN_ERR  = 3'd3,
      ST_DISCARD  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] header_value;
      logic [6:0] length_code_a;
      logic [6:0] length_code_b;
      logic [6:0] length_code_c;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [6:0] byte_count;
      logic [7:0] running_xor;
      logic [6:0] length_code;
   } frame_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [6:0] byte_index;
      logic       in_frame;
      logic       frame_end;
      status_type status;
   } result_type;

endpackage

// ===== hdl/rfc_frame_step.sv =====
// Per-byte frame tracking: next frame state and the result for one byte.
module rfc_frame_step (
   input  rfc_pkg::cfg_type         cfg,
   input  rfc_pkg::frame_state_type cur_state,
   input  logic [7:0]               rx_byte,
   output rfc_pkg::frame_state_type next_state,
   output rfc_pkg::result_type      result
);

   logic [6:0]         idx;
   logic               code_ok;
   logic [7:0]         last_idx;
   logic               last_hit;
   rfc_pkg::phase_type phase_next;
   logic [6:0]         count_next;
   logic [7:0]         xor_next;
   logic [6:0]         len_next;

   assign idx = cur_state.byte_count;

   // Length byte must be 7-bit, match a configured code, and fit in a frame
   assign code_ok = !rx_byte[7]
      && ((rx_byte[6:0] == cfg.length_code_a)
          || (rx_byte[6:0] == cfg.length_code_b)
          || (rx_byte[6:0] == cfg.length_code_c))
      && (({1'b0, rx_byte[6:0]} + 8'(rfc_pkg::EXTRA_BYTES)) <= 8'(rfc_pkg::MAX_FRAME));

   // Index of the checksum byte: code + 6 - 1
   assign last_idx = {1'b0, cur_state.length_code} + 8'(rfc_pkg::EXTRA_BYTES - 1);
   assign last_hit = ({1'b0, idx} >= last_idx);

   // Next phase
   always_comb begin
      unique case (cur_state.phase)
         rfc_pkg::PH_RECV: begin
            priority if (idx < 7'(rfc_pkg::LEN_POS)) begin
               phase_next = rfc_pkg::PH_RECV;
            end else if (idx == 7'(rfc_pkg::LEN_POS)) begin
               phase_next = code_ok ? rfc_pkg::PH_RECV : rfc_pkg::PH_HUNT;
            end else begin
               phase_next = last_hit ? rfc_pkg::PH_HUNT : rfc_pkg::PH_RECV;
            end
         end
         default: begin
            // hunting, or an unknown code that behaves as hunting
            phase_next = (rx_byte == cfg.header_value) ? rfc_pkg::PH_RECV
                                                       : rfc_pkg::PH_HUNT;
         end
      endcase
   end

   // Counters, checksum and result
   always_comb begin
      count_next        = idx + 7'd1;
      xor_next          = cur_state.running_xor ^ rx_byte;
      len_next          = cur_state.length_code;
      result.data_byte  = rx_byte;
      result.byte_index = idx;
      result.in_frame   = 1'b1;
      result.frame_end  = 1'b0;
      result.status     = rfc_pkg::ST_ONGOING;
      unique case (cur_state.phase)
         rfc_pkg::PH_RECV: begin
            priority if (idx < 7'(rfc_pkg::LEN_POS)) begin
               // header to length byte: just accumulate
            end else if (idx == 7'(rfc_pkg::LEN_POS)) begin
               if (code_ok) begin
                  len_next = rx_byte[6:0];
               end else begin
                  count_next       = '0;
                  xor_next         = '0;
                  result.frame_end = 1'b1;
                  result.status    = rfc_pkg::ST_LEN_ERR;
               end
            end else if (last_hit) begin
               // checksum byte closes the frame
               count_next       = '0;
               xor_next         = '0;
               result.frame_end = 1'b1;
               result.status    = (cur_state.running_xor == rx_byte)
                                  ? rfc_pkg::ST_GOOD : rfc_pkg::ST_CSUM_ERR;
            end else begin
               // payload byte
            end
         end
         default: begin
            result.byte_index = '0;
            if (rx_byte == cfg.header_value) begin
               count_next = 7'd1;
               xor_next   = rx_byte;
               len_next   = '0;
            end else begin
               count_next      = cur_state.byte_count;
               xor_next        = cur_state.running_xor;
               result.in_frame = 1'b0;
               result.status   = rfc_pkg::ST_DISCARD;
            end
         end
      endcase
   end

   assign next_state.phase       = phase_next;
   assign next_state.byte_count  = count_next;
   assign next_state.running_xor = xor_next;
   assign next_state.length_code = len_next;

endmodule

// ===== hdl/rx_frame_checker_top.sv =====
// Top level of the received-frame checker.
//
// Takes one received serial byte per request on the req_ channel and
// returns one result per byte on the rsp_ channel: the byte echoed, its
// index in the frame, in-frame and frame-end flags and a status code.
// Bytes that are not the configured header are reported as discarded
// while the block hunts; after a header, byte 4 must match one of the
// three length codes (and fit within 128 bytes) and the last byte is checked against the XOR of
// all earlier frame bytes.
// A request accepted on req_ passes through the input register, then
// the result register, before its result shows on rsp_.
// Throughput: one byte per cycle while rsp_stall does not hold the result register; the frame state updates in one pass
// of the step logic between the two registers.
// The input register can hold one request while the result register
// waits on rsp_stall; req_stall rises only once both are full.
// Reset (synchronous) empties both registers, returns to hunting and
// loads the default header and length codes. The csr_ port writes
// registers 0 to 3 and ignores other indexes; write only while idle.
`include "rx_frame_checker_top_defines.svh"

module rx_frame_checker_top (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic [6:0] rsp_byte_index,
   output logic       rsp_in_frame,
   output logic       rsp_frame_end,
   output logic [2:0] rsp_status,
   // configuration writes
   input  logic       csr_write_enable,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_wdata
);

   rfc_pkg::cfg_type         cfg_ff, cfg_in;
   rfc_pkg::frame_state_type state_ff, state_next;
   rfc_pkg::result_type      step_result, result_ff;
   logic                     s1_valid_ff, s1_valid_in;
   logic [7:0]               s1_byte_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;
   logic                     advance;
   logic                     req_accept;

   // Handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rfc_pkg::REG_HEADER_VALUE:  cfg_in.header_value  = csr_wdata;
            rfc_pkg::REG_LENGTH_CODE_A: cfg_in.length_code_a = csr_wdata[6:0];
            rfc_pkg::REG_LENGTH_CODE_B: cfg_in.length_code_b = csr_wdata[6:0];
            rfc_pkg::REG_LENGTH_CODE_C: cfg_in.length_code_c = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   rfc_frame_step u_step (
      .cfg        (cfg_ff),
      .cur_state  (state_ff),
      .rx_byte    (s1_byte_ff),
      .next_state (state_next),
      .result     (step_result)
   );

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value  <= rfc_pkg::HEADER_RESET;
         cfg_ff.length_code_a <= rfc_pkg::CODE_A_RESET;
         cfg_ff.length_code_b <= rfc_pkg::CODE_B_RESET;
         cfg_ff.length_code_c <= rfc_pkg::CODE_C_RESET;
         state_ff.phase       <= rfc_pkg::PH_HUNT;
         state_ff.byte_count  <= '0;
         state_ff.running_xor <= '0;
         state_ff.length_code <= '0;
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = result_ff.data_byte;
   assign rsp_byte_index = result_ff.byte_index;
   assign rsp_in_frame   = result_ff.in_frame;
   assign rsp_frame_end  = result_ff.frame_end;
   assign rsp_status     = result_ff.status;

   // Checks
   `RFC_ASSERT_ALWAYS(a_stall_only_when_full, !req_stall || (s1_valid_ff && rsp_valid_ff))
   `RFC_ASSERT_ALWAYS(a_discard_outside_frame, !(rsp_valid_ff && (result_ff.status == rfc_pkg::ST_DISCARD)) || (!result_ff.in_frame && !result_ff.frame_end && (result_ff.byte_index == 7'd0)))
   `RFC_ASSERT_ALWAYS(a_end_has_verdict, !(rsp_valid_ff && result_ff.frame_end) || (result_ff.status == rfc_pkg::ST_GOOD) || (result_ff.status == rfc_pkg::ST_CSUM_ERR) || (result_ff.status == rfc_pkg::ST_LEN_ERR))
   `RFC_ASSERT_NEXT(a_end_returns_to_hunt, advance && step_result.frame_end, (state_ff.phase == rfc_pkg::PH_HUNT) && (state_ff.byte_count == 7'd0) && (state_ff.running_xor == 8'd0))

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the received-frame checker: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

import rfc_pkg::*;

// Scoreboard: tracks the frame state and queues the expected result of each byte
class frame_scoreboard;
   cfg_type          cfg;
   frame_state_type  st;
   result_type       expected_results[$];
   int unsigned      mismatches;
   int unsigned      checked;
   int unsigned      good_frames;
   int unsigned      csum_errors;
   int unsigned      length_errors;
   int unsigned      discards;

   function new();
      cfg.header_value  = HEADER_RESET;
      cfg.length_code_a = CODE_A_RESET;
      cfg.length_code_b = CODE_B_RESET;
      cfg.length_code_c = CODE_C_RESET;
      st.phase          = PH_HUNT;
      st.byte_count     = '0;
      st.running_xor    = '0;
      st.length_code    = '0;
   endfunction

   // Register write; unknown indexes are dropped, extra data bits are cut off
   function void set_register(logic [7:0] idx, logic [7:0] value);
      case (idx)
         REG_HEADER_VALUE:  cfg.header_value  = value;
         REG_LENGTH_CODE_A: cfg.length_code_a = value[6:0];
         REG_LENGTH_CODE_B: cfg.length_code_b = value[6:0];
         REG_LENGTH_CODE_C: cfg.length_code_c = value[6:0];
         default: ;
      endcase
   endfunction

   // Length byte must be 7 bits, match a code and give a frame that fits
   function bit code_fits(logic [7:0] b);
      if (b[7])
         return 1'b0;
      if (b[6:0] != cfg.length_code_a && b[6:0] != cfg.length_code_b &&
          b[6:0] != cfg.length_code_c)
         return 1'b0;
      return (int'(b) + EXTRA_BYTES) <= MAX_FRAME;
   endfunction

   function void close_frame();
      st.phase       = PH_HUNT;
      st.byte_count  = '0;
      st.running_xor = '0;
   endfunction

   function void note_request(logic [7:0] b);
      result_type r;
      logic [6:0] idx;
      idx          = st.byte_count;
      r.data_byte  = b;
      r.byte_index = idx;
      r.in_frame   = 1'b1;
      r.frame_end  = 1'b0;
      r.status     = ST_ONGOING;
      if (st.phase != PH_RECV) begin
         // hunting: only the header opens a frame
         r.byte_index = '0;
         st.phase     = PH_HUNT;
         if (b != cfg.header_value) begin
            r.in_frame = 1'b0;
            r.status   = ST_DISCARD;
         end else begin
            st.phase       = PH_RECV;
            st.running_xor = b;
            st.byte_count  = 7'd1;
            st.length_code = '0;
         end
      end else if (idx < LEN_POS) begin
         st.running_xor = st.running_xor ^ b;
         st.byte_count  = idx + 7'd1;
      end else if (idx == LEN_POS) begin
         if (!code_fits(b)) begin
            r.frame_end = 1'b1;
            r.status    = ST_LEN_ERR;
            close_frame();
         end else begin
            st.length_code = b[6:0];
            st.running_xor = st.running_xor ^ b;
            st.byte_count  = idx + 7'd1;
         end
      end else if (int'(idx) >= int'(st.length_code) + EXTRA_BYTES - 1) begin
         // last byte carries the checksum
         r.frame_end = 1'b1;
         r.status    = (st.running_xor == b) ? ST_GOOD : ST_CSUM_ERR;
         close_frame();
      end else begin
         st.running_xor = st.running_xor ^ b;
         st.byte_count  = idx + 7'd1;
      end
      case (r.status)
         ST_GOOD:     good_frames++;
         ST_CSUM_ERR: csum_errors++;
         ST_LEN_ERR:  length_errors++;
         ST_DISCARD:  discards++;
         default: ;
      endcase
      expected_results.push_back(r);
   endfunction

   function void check_result(result_type got);
      result_type want;
      if (expected_results.size() == 0) begin
         if (mismatches < 10)
            $display("unexpected result: byte %h idx %0d status %0d",
                     got.data_byte, got.byte_index, got.status);
         mismatches++;
         return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
          got.in_frame !== want.in_frame || got.frame_end !== want.frame_end ||
          got.status !== want.status) begin
         if (mismatches < 10)
            $display("mismatch: want byte %h idx %0d in %b end %b st %0d, got %h %0d %b %b %0d",
                     want.data_byte, want.byte_index, want.in_frame, want.frame_end,
                     want.status, got.data_byte, got.byte_index, got.in_frame,
                     got.frame_end, got.status);
         mismatches++;
      end
   endfunction

   function int pending();
      return expected_results.size();
   endfunction
endclass

module testbench;

   localparam int         LONG_HOLD       = 400;
   localparam logic [7:0] REG_UNUSED_LOW  = 8'd4;
   localparam logic [7:0] REG_UNUSED_HIGH = 8'hFF;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_data_byte;
   logic [6:0] rsp_byte_index;
   logic       rsp_in_frame;
   logic       rsp_frame_end;
   logic [2:0] rsp_status;
   logic       csr_write_enable;
   logic [7:0] csr_index;
   logic [7:0] csr_wdata;

   frame_scoreboard sb = new();
   int  items_sent    = 0;
   int  settings_used = 0;
   int  long_holds    = 0;
   bit  quiet_stretch = 1'b0;
   bit  hold_long_req = 1'b0;

   rx_frame_checker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_in_frame     (rsp_in_frame),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (quiet_stretch)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // One of the configured codes, leaning toward short frames
   function automatic logic [7:0] pick_code();
      logic [6:0] codes [3];
      logic [6:0] c;
      logic [6:0] shortest;
      codes[0] = sb.cfg.length_code_a;
      codes[1] = sb.cfg.length_code_b;
      codes[2] = sb.cfg.length_code_c;
      shortest = codes[0];
      for (int i = 1; i < 3; i++)
         if (codes[i] < shortest)
            shortest = codes[i];
      c = codes[$urandom_range(0, 2)];
      if (c > 7'd16 && $urandom_range(0, 5) != 0)
         c = shortest;
      return {1'b0, c};
   endfunction

   // Offer one request; returns at the edge that takes it, valid left high
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(b);
      items_sent++;
   endtask

   // Header, three bytes, length byte, then payload and checksum if the code fits; keep > 0 cuts it short
   task automatic send_frame(input logic [7:0] len_byte, input bit bad_sum, input int keep);
      logic [7:0] frame_q [$];
      logic [7:0] sum;
      logic [7:0] b;
      int         total;
      sum = sb.cfg.header_value;
      frame_q.push_back(sum);
      for (int i = 1; i < LEN_POS; i++) begin
         b = 8'($urandom);
         frame_q.push_back(b);
         sum ^= b;
      end
      frame_q.push_back(len_byte);
      sum ^= len_byte;
      if (sb.code_fits(len_byte)) begin
         for (int i = LEN_POS + 1; i < int'(len_byte) + EXTRA_BYTES - 1; i++) begin
            b = 8'($urandom);
            frame_q.push_back(b);
            sum ^= b;
         end
         frame_q.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
      end
      total = (keep > 0 && keep < frame_q.size()) ? keep : frame_q.size();
      for (int i = 0; i < total; i++)
         send_byte(frame_q[i]);
   endtask

   // Sender goes quiet until every outstanding result has been checked
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(posedge clock);
      sb.set_register(idx, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_codes(input logic [7:0] hdr, input logic [7:0] a,
                            input logic [7:0] b, input logic [7:0] c);
      drain();
      write_reg(REG_HEADER_VALUE, hdr);
      write_reg(REG_LENGTH_CODE_A, a);
      write_reg(REG_LENGTH_CODE_B, b);
      write_reg(REG_LENGTH_CODE_C, c);
      settings_used++;
   endtask

   // Mostly well-formed frames with random content, plus noise and broken frames
   task automatic random_traffic(input int n);
      int         stop_at;
      int         pick;
      logic [7:0] code;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         quiet_stretch = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         code = pick_code();
         if (pick < 10)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         else if (pick < 16)
            send_frame(8'($urandom_range(128, 255)), 1'b0, 0);
         else if (pick < 22)
            send_frame(8'($urandom), 1'b0, 0);
         else if (pick < 30)
            send_frame(code, 1'b0, $urandom_range(1, int'(code) + EXTRA_BYTES - 1));
         else
            send_frame(code, $urandom_range(0, 3) == 0, 0);
      end
      quiet_stretch = 1'b0;
   endtask

   // Result side: random stall bursts, quiet stretches and the long hold-off
   initial begin
      int n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_long_req) begin
            hold_long_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_holds++;
         end else if (!quiet_stretch && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            n = pick_gap() + 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         n = quiet_stretch ? $urandom_range(8, 20) : $urandom_range(1, 6);
         repeat (n) @(posedge clock);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      result_type got;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.data_byte  = rsp_data_byte;
         got.byte_index = rsp_byte_index;
         got.in_frame   = rsp_in_frame;
         got.frame_end  = rsp_frame_end;
         got.status     = status_type'(rsp_status);
         sb.check_result(got);
      end
   end

   // Main sequence
   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_rx_byte      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, byte extremes while hunting, length byte above 127
      settings_used++;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'h80, 1'b0, 0);

      // directed: equal zero codes, good and bad checksum, oversized code
      set_codes(8'hA5, 8'h00, 8'h00, 8'h7B);
      send_frame(8'h00, 1'b0, 0);
      send_frame(8'h00, 1'b1, 0);
      send_frame(8'h7B, 1'b0, 0);

      // zero header, largest legal frame, code written with extra data bits
      set_codes(8'h00, 8'h01, 8'd122, 8'hFF);
      send_frame(8'd122, 1'b0, 0);
      random_traffic(100);

      // all-ones header, duplicated code, writes to unused indexes
      set_codes(8'hFF, 8'h03, 8'h03, 8'h80);
      write_reg(REG_UNUSED_LOW, 8'h5A);
      write_reg(REG_UNUSED_HIGH, 8'h00);
      random_traffic(100);

      // back to default settings; receiver holds off while bytes keep coming
      set_codes(HEADER_RESET, {1'b0, CODE_A_RESET}, {1'b0, CODE_B_RESET},
                {1'b0, CODE_C_RESET});
      hold_long_req = 1'b1;
      random_traffic(70);

      // random header and short codes
      set_codes(8'($urandom), 8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                8'($urandom_range(0, 12)));
      random_traffic(70);
      hold_long_req = 1'b1;
      random_traffic(70);

      drain();
      repeat (8) @(posedge clock);

      $display("run: %0d bytes under %0d settings, %0d results checked, %0d long hold-offs",
               items_sent, settings_used, sb.checked, long_holds);
      $display("     %0d good frames, %0d checksum errors, %0d length errors, %0d discarded",
               sb.good_frames, sb.csum_errors, sb.length_errors, sb.discards);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rfc_pkg.sv
hdl/rfc_frame_step.sv
hdl/rx_frame_checker_top.sv
tb/sv/testbench.sv
